FILE: hdl/xeu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML entity unescaper package
// Shared types, entity tables and helpers for the entity unescaper unit.
// ----------------------------------------------------------------------------
package xeu_pkg;

   localparam int unsigned CsrWidth         = 13;
   localparam int unsigned MaxBufferDefault = 4096;
   localparam int unsigned BufferSizeReset  = 256;
   localparam int unsigned MaxResults       = 7;
   localparam int unsigned EntCount         = 5;
   localparam int unsigned EntMaxLen        = 5;
   localparam int unsigned HeldDepth        = 4;

   typedef logic [7:0] char_type;
   typedef logic [2:0] small_count_type;

   localparam char_type AmpChar = 8'h26;

   // Entity names as they follow the ampersand, terminator included.
   localparam char_type EntText [EntCount][EntMaxLen] = '{
      '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
      '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
      '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
      '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
      '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}
   };
   localparam small_count_type EntLen [EntCount] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
   localparam char_type EntChar [EntCount] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};

   typedef struct packed {
      logic     has_char;
      char_type in_char;
      logic     last_char;
   } req_type;

   typedef struct packed {
      char_type out_char;
      logic     is_end;
   } rsp_type;

   // Characters produced by one request, packed from index 0, plus the
   // terminator flag that follows them.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] chars;
      small_count_type            nchar;
      logic                       last;
   } dec_type;

   function automatic char_type fold(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: hdl/xeu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Entity decoder
// Holds the pending entity state and turns one registered request into the
// list of characters it produces, limited by the remaining capacity.
// ----------------------------------------------------------------------------
module xeu_decode #(
   parameter int unsigned MAX_BUFFER = xeu_pkg::MaxBufferDefault,
   localparam int unsigned CountWidth = $clog2(MAX_BUFFER)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  xeu_pkg::req_type      in_item,
   input  logic [CountWidth-1:0] limit,
   output xeu_pkg::dec_type      result
);

   logic                      amp_ff, amp_in;
   xeu_pkg::small_count_type  cnt_ff, cnt_in;
   xeu_pkg::char_type         held_ff [xeu_pkg::HeldDepth];
   xeu_pkg::char_type         held_in [xeu_pkg::HeldDepth];
   logic [CountWidth-1:0]     emitted_ff, emitted_in;

   logic                      has, last;
   xeu_pkg::char_type         c;
   xeu_pkg::small_count_type  len;
   xeu_pkg::char_type         cand [xeu_pkg::EntMaxLen];
   logic [xeu_pkg::EntCount-1:0] full_vec, part_vec;
   logic                      ok;
   logic                      full_any, partial;
   xeu_pkg::char_type         mchar;
   logic                      matched, hold, flush_f, c_en, amp_start;
   xeu_pkg::small_count_type  fcount;
   xeu_pkg::char_type         slot [xeu_pkg::MaxResults];
   logic [xeu_pkg::MaxResults-1:0] slot_en;
   logic [xeu_pkg::MaxResults-1:0][7:0] chars;
   xeu_pkg::small_count_type  total_en;
   logic [CountWidth-1:0]     room_val;
   xeu_pkg::small_count_type  room3;
   xeu_pkg::small_count_type  nchar;
   logic [CountWidth+2:0]     emitted_sum;

   assign has  = in_item.has_char;
   assign c    = in_item.in_char;
   assign last = in_item.last_char;
   assign len  = cnt_ff + 3'd1;

   // Match the held name bytes plus the new byte against every entity.
   always_comb begin
      for (int i = 0; i < xeu_pkg::HeldDepth; i++) begin
         cand[i] = (3'(i) < cnt_ff) ? held_ff[i] : c;
      end
      cand[xeu_pkg::EntMaxLen-1] = c;
      full_vec = '0;
      part_vec = '0;
      mchar    = '0;
      for (int e = 0; e < xeu_pkg::EntCount; e++) begin
         ok = (len <= xeu_pkg::EntLen[e]);
         for (int i = 0; i < xeu_pkg::EntMaxLen; i++) begin
            if (3'(i) < len && xeu_pkg::fold(cand[i]) != xeu_pkg::EntText[e][i]) begin
               ok = 1'b0;
            end
         end
         full_vec[e] = ok && (len == xeu_pkg::EntLen[e]);
         part_vec[e] = ok && (len < xeu_pkg::EntLen[e]);
         if (full_vec[e]) begin
            mchar = xeu_pkg::EntChar[e];
         end
      end
   end

   assign full_any = |full_vec;
   assign partial  = |part_vec;
   assign matched  = has && amp_ff && full_any;
   assign hold     = has && amp_ff && !full_any && partial && (cnt_ff < 3'd4);
   assign flush_f  = amp_ff && !matched && (hold ? last : (has || last));
   assign fcount   = flush_f ? len : 3'd0;
   // A new byte is emitted unless it joins a match; an ampersand is only
   // emitted when the value ends right after it.
   assign c_en     = has && !matched && (hold ? last : ((c != xeu_pkg::AmpChar) || last));

   // Remaining capacity, saturated to the most a request can produce.
   assign room_val = limit - emitted_ff;
   always_comb begin
      if (limit <= emitted_ff) begin
         room3 = 3'd0;
      end else if ({3'b000, room_val} >= (CountWidth + 3)'(xeu_pkg::MaxResults)) begin
         room3 = 3'(xeu_pkg::MaxResults);
      end else begin
         room3 = 3'(room_val);
      end
   end

   assign amp_start = has && !matched && !hold && (c == xeu_pkg::AmpChar) && (room3 > fcount);

   // Candidate characters in output order, then packed toward index 0.
   always_comb begin
      slot[0]    = xeu_pkg::AmpChar;
      slot_en[0] = flush_f;
      for (int k = 0; k < xeu_pkg::HeldDepth; k++) begin
         slot[k+1]    = held_ff[k];
         slot_en[k+1] = flush_f && (3'(k) < cnt_ff);
      end
      slot[5]    = mchar;
      slot_en[5] = matched;
      slot[6]    = c;
      slot_en[6] = c_en;
      chars    = '0;
      total_en = '0;
      for (int j = 0; j < xeu_pkg::MaxResults; j++) begin
         if (slot_en[j]) begin
            chars[total_en] = slot[j];
            total_en = total_en + 3'd1;
         end
      end
   end

   assign nchar = (total_en < room3) ? total_en : room3;

   assign result.chars = chars;
   assign result.nchar = nchar;
   assign result.last  = last;

   assign emitted_sum = {3'b000, emitted_ff} + (CountWidth + 3)'(nchar);

   always_comb begin
      amp_in     = amp_ff;
      cnt_in     = cnt_ff;
      held_in    = held_ff;
      emitted_in = emitted_ff;
      if (advance) begin
         emitted_in = emitted_sum[CountWidth-1:0];
         if (last) begin
            amp_in     = 1'b0;
            cnt_in     = 3'd0;
            emitted_in = '0;
         end else if (hold) begin
            held_in[cnt_ff[1:0]] = c;
            cnt_in = len;
         end else if (amp_start) begin
            amp_in = 1'b1;
            cnt_in = 3'd0;
         end else if (has) begin
            amp_in = 1'b0;
            cnt_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff     <= 1'b0;
         cnt_ff     <= 3'd0;
         emitted_ff <= '0;
         for (int i = 0; i < xeu_pkg::HeldDepth; i++) begin
            held_ff[i] <= '0;
         end
      end else begin
         amp_ff     <= amp_in;
         cnt_ff     <= cnt_in;
         held_ff    <= held_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

FILE: hdl/xeu_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Registers the character list of one request and hands it out one result
// per cycle while the receiver is ready, terminator last.
// ----------------------------------------------------------------------------
module xeu_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  xeu_pkg::dec_type in_list,
   output logic             buf_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xeu_pkg::rsp_type rsp_data
);

   logic                     valid_ff, valid_in;
   xeu_pkg::small_count_type idx_ff, idx_in;
   xeu_pkg::dec_type         list_ff, list_in;
   xeu_pkg::small_count_type total, in_total;
   logic                     final_out;

   assign total     = list_ff.nchar + {2'b00, list_ff.last};
   assign in_total  = in_list.nchar + {2'b00, in_list.last};
   assign final_out = rsp_ready && (idx_ff == total - 3'd1);
   assign buf_ready = !valid_ff || final_out;

   assign rsp_valid         = valid_ff;
   assign rsp_data.out_char = (idx_ff < list_ff.nchar) ? list_ff.chars[idx_ff] : '0;
   assign rsp_data.is_end   = (idx_ff >= list_ff.nchar);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      list_in  = list_ff;
      if (load) begin
         valid_in = (in_total != 3'd0);
         idx_in   = 3'd0;
         list_in  = in_list;
      end else if (valid_ff && rsp_ready) begin
         if (final_out) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      list_ff <= list_in;
   end

endmodule

FILE: hdl/xml_entity_unescaper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML entity unescaper unit
// Decodes the five predefined XML entities in a stream of attribute bytes.
// ----------------------------------------------------------------------------
// One request is accepted per cycle while each produces at most one result
// and the receiver takes each; a request that produces k results holds the
// result register until all are taken (k is at most 7: a flushed entity, the
// byte that broke it and the terminator), and input waits behind it. The first
// result of a request waits in the request register until the result register
// is free, then is loaded into it and presented. The capacity register is
// written through csr_wr_en / csr_wr_data; the user writes it only while
// the unit is idle, not enforced here, and it takes effect with the next value.
module xml_entity_unescaper_unit #(
   parameter int unsigned MAX_BUFFER = xeu_pkg::MaxBufferDefault,
   localparam int unsigned CountWidth = $clog2(MAX_BUFFER)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  xeu_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output xeu_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [xeu_pkg::CsrWidth-1:0]  csr_wr_data
);

   localparam int unsigned CalcWidth =
      ((CountWidth + 1 > xeu_pkg::CsrWidth) ? CountWidth + 1 : xeu_pkg::CsrWidth) + 1;
   localparam int unsigned LimitReset =
      ((xeu_pkg::BufferSizeReset > MAX_BUFFER) ? MAX_BUFFER : xeu_pkg::BufferSizeReset) - 1;

   logic [CountWidth-1:0] limit_ff, limit_in;
   logic [CalcWidth-1:0]  size_ext, size_clamp;
   logic                  in_valid_ff, in_valid_in;
   xeu_pkg::req_type      in_item_ff, in_item_in;
   logic                  load;
   logic                  buf_ready;
   xeu_pkg::dec_type      dec_list;

   // Capacity zero acts as one; anything above the maximum is clamped.
   assign size_ext = CalcWidth'(csr_wr_data);
   always_comb begin
      size_clamp = size_ext;
      if (size_ext == '0) begin
         size_clamp = CalcWidth'(1);
      end else if (size_ext > CalcWidth'(MAX_BUFFER)) begin
         size_clamp = CalcWidth'(MAX_BUFFER);
      end
   end
   assign limit_in = csr_wr_en ? CountWidth'(size_clamp - CalcWidth'(1)) : limit_ff;

   assign load      = in_valid_ff && buf_ready;
   assign req_ready = !in_valid_ff || load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= CountWidth'(LimitReset);
         in_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   xeu_decode #(
      .MAX_BUFFER(MAX_BUFFER)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (load),
      .in_item (in_item_ff),
      .limit   (limit_ff),
      .result  (dec_list)
   );

   xeu_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .in_list   (dec_list),
      .buf_ready (buf_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/xml_entity_unescaper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML entity unescaper unit testbench
// Streams attribute values through the unit (directed entities first, then
// random values of plain bytes and whole, broken and numeric references) under
// several capacity settings and idling patterns. A scoreboard decodes every
// accepted request on its own and checks each result in order.
// ----------------------------------------------------------------------------

localparam int unsigned CapacityCeiling = 4096;
localparam xeu_pkg::char_type AmpByte = 8'h26;
localparam string EntityNames [5] = '{"amp;", "lt;", "gt;", "quot;", "apos;"};

class entity_decode_board;
   logic [12:0]       capacity;
   xeu_pkg::char_type held [4];
   int                held_n;
   bit                amp_open;
   int                emitted;
   int                step_results;
   xeu_pkg::char_type glyph [5];
   xeu_pkg::rsp_type  expected_chars [$];
   int                failures;

   function new();
      capacity = 13'd256;
      held     = '{default: 8'h00};
      held_n   = 0;
      amp_open = 1'b0;
      emitted  = 0;
      failures = 0;
      glyph    = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27};
   endfunction

   function void set_capacity(logic [12:0] value);
      capacity = value;
   endfunction

   function int char_limit();
      int b;
      b = int'(capacity);
      if (b < 1) b = 1;
      if (b > CapacityCeiling) b = CapacityCeiling;
      return b - 1;
   endfunction

   function xeu_pkg::char_type to_lower(xeu_pkg::char_type c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function void emit(xeu_pkg::char_type c, logic is_end);
      xeu_pkg::rsp_type r;
      if (step_results >= 7) return;
      r.out_char = c;
      r.is_end   = is_end;
      expected_chars.push_back(r);
      step_results++;
   endfunction

   function void put_char(xeu_pkg::char_type c);
      if (emitted < char_limit()) begin
         emit(c, 1'b0);
         emitted++;
      end
   endfunction

   function void flush_raw();
      if (!amp_open) return;
      put_char(AmpByte);
      for (int i = 0; i < held_n && i < 4; i++) put_char(held[i]);
      amp_open = 1'b0;
      held_n   = 0;
   endfunction

   function void take_byte(xeu_pkg::char_type c);
      xeu_pkg::char_type cand [5];
      int n;
      int len;
      int full;
      bit partial;
      bit ok;
      if (amp_open) begin
         n       = (held_n > 4) ? 4 : held_n;
         len     = n + 1;
         partial = 1'b0;
         full    = -1;
         for (int i = 0; i < n; i++) cand[i] = held[i];
         cand[n] = c;
         for (int e = 0; e < 5; e++) begin
            ok = (len <= EntityNames[e].len());
            for (int i = 0; ok && i < len; i++) begin
               if (to_lower(cand[i]) != EntityNames[e][i]) ok = 1'b0;
            end
            if (ok) begin
               if (len == EntityNames[e].len()) full = e;
               else partial = 1'b1;
            end
         end
         if (full >= 0) begin
            put_char(glyph[full]);
            amp_open = 1'b0;
            held_n   = 0;
            return;
         end
         if (partial && n < 4) begin
            held[n] = c;
            held_n  = n + 1;
            return;
         end
         // The byte broke the match: the held text goes out raw and the byte
         // is scanned again on its own.
         flush_raw();
      end
      if (emitted >= char_limit()) return;
      if (c == AmpByte) begin
         amp_open = 1'b1;
         held_n   = 0;
      end else begin
         put_char(c);
      end
   endfunction

   function void note_request(xeu_pkg::req_type r);
      step_results = 0;
      if (r.has_char) take_byte(r.in_char);
      if (r.last_char) begin
         flush_raw();
         emit(8'h00, 1'b1);
         held_n   = 0;
         amp_open = 1'b0;
         emitted  = 0;
      end
   endfunction

   function void check_result(xeu_pkg::rsp_type got);
      xeu_pkg::rsp_type want;
      if (expected_chars.size() == 0) begin
         failures++;
         if (failures <= 10) begin
            $display("unexpected result: char %h end %b", got.out_char, got.is_end);
         end
         return;
      end
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char || got.is_end !== want.is_end) begin
         failures++;
         if (failures <= 10) begin
            $display("result mismatch: expected char %h end %b, got char %h end %b",
                     want.out_char, want.is_end, got.out_char, got.is_end);
         end
      end
   endfunction

   function int outstanding();
      return expected_chars.size();
   endfunction
endclass

module xml_entity_unescaper_unit_tb;

   localparam int SettleCycles   = 12;
   localparam int PhaseItems     = 22;
   localparam int TimeoutNs      = 2_000_000;
   localparam int SendIdle [4]   = '{0, 59, 0, 26};
   localparam int RecvStall [4]  = '{0, 0, 59, 26};
   localparam int Capacities [10] = '{1, 0, 2, 3, 5, 8191, 4096, 4097, 7, 256};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   xeu_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   xeu_pkg::rsp_type  rsp_data;
   logic              csr_wr_en;
   logic [12:0]       csr_wr_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   entity_decode_board decode_board = new();

   xml_entity_unescaper_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) decode_board.note_request(req_data);
         if (rsp_valid && rsp_ready) decode_board.check_result(rsp_data);
      end
   end

   initial begin
      #(TimeoutNs * 1ns);
      $display("Test completed with failures");
      $finish;
   end

   function automatic xeu_pkg::req_type byte_req(xeu_pkg::char_type c);
      xeu_pkg::req_type r;
      r.has_char  = 1'b1;
      r.in_char   = c;
      r.last_char = 1'b0;
      return r;
   endfunction

   function automatic xeu_pkg::char_type random_case(xeu_pkg::char_type c);
      if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
         return c - 8'd32;
      end
      return c;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input xeu_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input bit close_value);
      xeu_pkg::req_type r;
      for (int i = 0; i < s.len(); i++) begin
         r = byte_req(s[i]);
         r.last_char = close_value && (i == s.len() - 1);
         send_request(r);
      end
   endtask

   task automatic wait_for_idle();
      req_valid = 1'b0;
      while (decode_board.outstanding() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [12:0] value);
      decode_board.set_capacity(value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // One attribute value: a few pieces of plain bytes, entities, broken
   // entities and numeric references, with empty requests mixed in.
   task automatic send_random_value(output int sent);
      xeu_pkg::req_type q [$];
      xeu_pkg::req_type r;
      string   name;
      int      kind;
      int      cut;
      sent = 0;
      repeat ($urandom_range(1, 8)) begin
         kind = $urandom_range(0, 9);
         name = EntityNames[$urandom_range(0, 4)];
         case (kind)
            0, 1: q.push_back(byte_req(8'($urandom_range(0, 255))));
            2, 3: q.push_back(byte_req(8'($urandom_range(8'h20, 8'h7e))));
            4, 5, 6: begin
               q.push_back(byte_req(AmpByte));
               for (int k = 0; k < name.len(); k++) q.push_back(byte_req(random_case(name[k])));
            end
            7: begin
               cut = $urandom_range(1, name.len() - 1);
               q.push_back(byte_req(AmpByte));
               for (int k = 0; k < cut; k++) q.push_back(byte_req(random_case(name[k])));
               if ($urandom_range(0, 1)) begin
                  q.push_back(byte_req($urandom_range(0, 1) ? 8'h3b :
                                       8'($urandom_range(0, 255))));
               end
            end
            8: begin
               q.push_back(byte_req(AmpByte));
               q.push_back(byte_req("#"));
               repeat ($urandom_range(1, 3)) begin
                  q.push_back(byte_req(8'h30 + 8'($urandom_range(0, 9))));
               end
               q.push_back(byte_req(";"));
            end
            default: begin
               r.has_char  = 1'b0;
               r.in_char   = 8'($urandom_range(0, 255));
               r.last_char = 1'b0;
               q.push_back(r);
            end
         endcase
      end
      if ($urandom_range(0, 2) == 0 || q.size() == 0 || !q[$].has_char) begin
         r.has_char  = 1'b0;
         r.in_char   = 8'($urandom_range(0, 255));
         r.last_char = 1'b1;
         q.push_back(r);
      end else begin
         r = q.pop_back();
         r.last_char = 1'b1;
         q.push_back(r);
      end
      foreach (q[i]) begin
         send_request(q[i]);
         if (q[i].has_char || q[i].last_char) sent++;
      end
   endtask

   initial begin
      xeu_pkg::req_type r;
      int      phase_items;
      int      sent;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed values at the reset capacity: every entity, most in mixed case, a
      // truncated entity closed by an end-only request after an empty one.
      send_text("&aMp;&LT;", 1'b1);
      send_text("&qUOt;&Apos;", 1'b1);
      send_text("&gT", 1'b0);
      r.has_char  = 1'b0;
      r.in_char   = 8'hff;
      r.last_char = 1'b0;
      send_request(r);
      r.in_char   = 8'h00;
      r.last_char = 1'b1;
      send_request(r);
      send_text("&gt;", 1'b1);

      for (int p = 0; p < 10; p++) begin
         // The sender holds off here until every result is back, so the
         // capacity write lands on an idle unit between values.
         wait_for_idle();
         write_capacity(13'(Capacities[p]));
         send_idle_pct  = SendIdle[p % 4];
         recv_stall_pct = RecvStall[p % 4];
         phase_items = 0;
         while (phase_items < PhaseItems) begin
            send_random_value(sent);
            phase_items += sent;
         end
      end

      wait_for_idle();
      if (decode_board.failures == 0 && decode_board.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
